@@ sv/tws_pkg.sv @@
// tws_pkg: shared constants, command codes, glyph table and engine interface types
// for the text window console. No dependencies.
package tws_pkg;

    localparam int SCREEN_COLS        = 80;
    localparam int SCREEN_ROWS        = 25;
    localparam int CURSOR_STACK_DEPTH = 8;
    localparam int ATTRIB_STACK_DEPTH = 8;

    localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CIDX_W = (CURSOR_STACK_DEPTH > 1) ? $clog2(CURSOR_STACK_DEPTH) : 1;
    localparam int CCNT_W = $clog2(CURSOR_STACK_DEPTH + 1);
    localparam int AIDX_W = (ATTRIB_STACK_DEPTH > 1) ? $clog2(ATTRIB_STACK_DEPTH) : 1;
    localparam int ACNT_W = $clog2(ATTRIB_STACK_DEPTH + 1);

    localparam logic [4:0] ROW_LIMIT  = 5'd31;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // command kinds
    localparam logic [3:0] K_PUT       = 4'd0;
    localparam logic [3:0] K_MOVE      = 4'd1;
    localparam logic [3:0] K_PUSH_CCUR = 4'd2;
    localparam logic [3:0] K_PUSH_CUR  = 4'd3;
    localparam logic [3:0] K_POP_CUR   = 4'd4;
    localparam logic [3:0] K_PUSH_CATT = 4'd5;
    localparam logic [3:0] K_PUSH_ATT  = 4'd6;
    localparam logic [3:0] K_POP_ATT   = 4'd7;
    localparam logic [3:0] K_BORDER    = 4'd8;
    localparam logic [3:0] K_READ      = 4'd9;
    localparam logic [3:0] K_RECOL     = 4'd10;

    // config register indexes
    localparam logic [2:0] R_LEFT  = 3'd0;
    localparam logic [2:0] R_TOP   = 3'd1;
    localparam logic [2:0] R_COLS  = 3'd2;
    localparam logic [2:0] R_ROWS  = 3'd3;
    localparam logic [2:0] R_DATTR = 3'd4;

    // cell engine operations
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_SCROLL = 3'd2;
    localparam logic [2:0] OP_RECOL  = 3'd3;
    localparam logic [2:0] OP_BORDER = 3'd4;

    // glyph slots
    localparam logic [2:0] G_TL = 3'd0;
    localparam logic [2:0] G_TR = 3'd1;
    localparam logic [2:0] G_BL = 3'd2;
    localparam logic [2:0] G_BR = 3'd3;
    localparam logic [2:0] G_H  = 3'd4;
    localparam logic [2:0] G_V  = 3'd5;

    typedef struct packed {
        logic              go;
        logic [2:0]        op;
        logic signed [9:0] x;
        logic signed [9:0] y;
        logic [7:0]        cols;
        logic [5:0]        rows;
        logic [15:0]       data;   // [15:8] attribute, [7:0] char (bit 0 = thick for border)
    } eng_req_t;

    typedef struct packed {
        logic        ready;
        logic        done;
        logic [15:0] rdata;
    } eng_stat_t;

    function automatic logic on_screen(input logic signed [9:0] x, input logic signed [9:0] y);
        on_screen = (x >= 0) && (x < SCREEN_COLS) && (y >= 0) && (y < SCREEN_ROWS);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [9:0] x,
                                                    input logic signed [9:0] y);
        cell_addr = ADDR_W'(int'(y) * SCREEN_COLS + int'(x));
    endfunction

    function automatic logic [7:0] glyph(input logic thick, input logic [2:0] slot);
        logic [7:0] g;
        g = 8'd0;
        unique case (slot)
            G_TL:    g = thick ? 8'd201 : 8'd218;
            G_TR:    g = thick ? 8'd187 : 8'd191;
            G_BL:    g = thick ? 8'd200 : 8'd192;
            G_BR:    g = thick ? 8'd188 : 8'd217;
            G_H:     g = thick ? 8'd205 : 8'd196;
            default: g = thick ? 8'd186 : 8'd179;
        endcase
        glyph = g;
    endfunction

endpackage

@@ sv/tws_ram.sv @@
// tws_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/tws_cell_engine.sv @@
// tws_cell_engine: sequencer over the cell store (clear, single write/read,
// scroll, recolour, border walks). Depends on tws_pkg and tws_ram.
module tws_cell_engine import tws_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  eng_req_t  req,
    output eng_stat_t stat
);
    localparam logic [1:0] E_IDLE  = 2'd0;
    localparam logic [1:0] E_CLEAR = 2'd1;
    localparam logic [1:0] E_RD    = 2'd2;
    localparam logic [1:0] E_WR    = 2'd3;

    logic [1:0]        st_reg, st_next;
    logic [2:0]        op_reg;
    logic signed [9:0] bx_reg, by_reg;
    logic [7:0]        cols_reg;
    logic [5:0]        rows_reg;
    logic [15:0]       data_reg;
    logic [7:0]        xi_reg, xi_next;
    logic [5:0]        yi_reg, yi_next;
    logic              rd_ok_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic              done_reg;
    logic [15:0]       rdata_reg;

    logic signed [9:0] cx, cy, wy;
    logic              fill, brow, x_last_in, x_last_b, last;
    logic [2:0]        gslot;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [15:0]       ram_wdata, ram_q;

    tws_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_q)
    );

    always_comb begin
        cx        = bx_reg + signed'({2'b00, xi_reg});
        cy        = by_reg + signed'({4'b0000, yi_reg});
        wy        = (op_reg == OP_SCROLL) ? cy - 10'sd1 : cy;
        fill      = (op_reg == OP_SCROLL) && (yi_reg == rows_reg);
        brow      = (yi_reg == 6'd0) || (yi_reg == rows_reg + 6'd1);
        x_last_in = (xi_reg == cols_reg - 8'd1);
        x_last_b  = (xi_reg == cols_reg + 8'd1);

        if (xi_reg == 8'd0) begin
            gslot = (yi_reg == 6'd0) ? G_TL : (brow ? G_BL : G_V);
        end else if (x_last_b) begin
            gslot = (yi_reg == 6'd0) ? G_TR : (brow ? G_BR : G_V);
        end else begin
            gslot = G_H;
        end

        unique case (op_reg)
            OP_SCROLL: ram_wdata = fill ? {data_reg[15:8], CH_SPACE}
                                        : (rd_ok_reg ? ram_q : 16'd0);
            OP_RECOL:  ram_wdata = {data_reg[15:8], ram_q[7:0]};
            OP_BORDER: ram_wdata = {data_reg[15:8], glyph(data_reg[0], gslot)};
            default:   ram_wdata = data_reg;
        endcase

        ram_raddr = cell_addr(cx, cy);
        if (st_reg == E_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = 16'd0;
        end else begin
            ram_we    = (st_reg == E_WR) && (op_reg != OP_READ) && on_screen(cx, wy);
            ram_waddr = cell_addr(cx, wy);
        end

        // walk advance after a write slot
        xi_next = xi_reg + 8'd1;
        yi_next = yi_reg;
        last    = 1'b1;
        unique case (op_reg)
            OP_SCROLL, OP_RECOL: begin
                last = 1'b0;
                if (x_last_in) begin
                    xi_next = 8'd0;
                    yi_next = yi_reg + 6'd1;
                    last    = (op_reg == OP_SCROLL) ? (yi_reg == rows_reg)
                                                    : (yi_reg == rows_reg - 6'd1);
                end
            end
            OP_BORDER: begin
                last = 1'b0;
                if (x_last_b) begin
                    xi_next = 8'd0;
                    yi_next = yi_reg + 6'd1;
                    last    = (yi_reg == rows_reg + 6'd1);
                end else if (!brow) begin
                    xi_next = cols_reg + 8'd1;   // side rows: jump to right edge
                end
            end
            default: last = 1'b1;
        endcase

        st_next = st_reg;
        unique case (st_reg)
            E_CLEAR: if (clr_reg == ADDR_W'(CELLS - 1)) st_next = E_IDLE;
            E_IDLE: begin
                if (req.go) begin
                    st_next = ((req.op == OP_WRITE) || (req.op == OP_BORDER) ||
                               ((req.op == OP_SCROLL) && (req.rows == 6'd1))) ? E_WR : E_RD;
                end
            end
            E_RD: st_next = E_WR;
            default: begin
                if (last) begin
                    st_next = E_IDLE;
                end else if ((op_reg == OP_BORDER) ||
                             ((op_reg == OP_SCROLL) && (yi_next == rows_reg))) begin
                    st_next = E_WR;
                end else begin
                    st_next = E_RD;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= E_CLEAR;
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= (st_reg == E_WR) && last;
            if (st_reg == E_CLEAR) clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == E_IDLE && req.go) begin
            op_reg   <= req.op;
            bx_reg   <= req.x;
            by_reg   <= req.y;
            cols_reg <= req.cols;
            rows_reg <= req.rows;
            data_reg <= req.data;
            xi_reg   <= 8'd0;
            yi_reg   <= (req.op == OP_SCROLL) ? 6'd1 : 6'd0;
        end
        if (st_reg == E_RD) rd_ok_reg <= on_screen(cx, cy);
        if (st_reg == E_WR) begin
            xi_reg <= xi_next;
            yi_reg <= yi_next;
            if (op_reg == OP_READ) rdata_reg <= rd_ok_reg ? ram_q : 16'd0;
        end
    end

    assign stat = '{ready: (st_reg == E_IDLE), done: done_reg, rdata: rdata_reg};

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> st_reg == E_IDLE) else $error("done while walking");
    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && st_reg != E_CLEAR) |-> ram_waddr < ADDR_W'(CELLS))
        else $error("write outside store");
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == E_IDLE && req.go) |=> (st_reg == E_RD || st_reg == E_WR))
        else $error("request not taken");
endmodule

@@ sv/text_window_console.sv @@
// text_window_console: top level; command decode, cursor and attribute stacks,
// config registers and stream handshakes. Depends on tws_pkg, tws_cell_engine.
//
// Usage:
//  - s_* stream carries one command word (kind in s_tuser). m_* returns one
//    result word per command. cfg_* writes window registers (index 0..4);
//    write only while no command is in flight.
//  - After reset the cell store is cleared, one cell per cycle, while
//    s_tready stays low. Stacks hold their reset entries.
//  - A new word is taken only once the previous command has put its result
//    into the output register. Scroll copies the window rows up by one and
//    blanks the bottom row, each copied cell with a read and a write step and
//    each blanked cell with a write step; recolour reads and writes every
//    window cell, border writes every perimeter cell; a put past the bottom
//    row scrolls once per row it is past.
//  - One command at a time: s_tready is high only while the control is idle.
//  - The result sits in an output register; the next command is taken while
//    it waits. If m_tready stays low, the following command completes its
//    work and then holds until the register frees.
module text_window_console import tws_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [3:0]  s_tuser,   // kind
    // [7:0] char_code, [14:8] pos_col, [19:15] pos_row, [27:20] attrib_value,
    // [28] thick_border, [31:29] zero
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] cell_char, [15:8] cell_attrib, [22:16] cursor_col, [27:23] cursor_row,
    // [35:28] current_attrib, [36] stack_full, [39:37] zero
    output logic [39:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_PUTCHK = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [6:0] left_reg, cols_reg;
    logic [4:0] top_reg, rows_reg;
    logic [7:0] dattr_reg;

    logic [3:0] kind_reg;
    logic [7:0] ch_reg, av_reg;
    logic [6:0] pc_reg;
    logic [4:0] pr_reg;
    logic       thick_reg;

    logic [6:0] wc_reg;
    logic [4:0] wr_reg;
    logic       after_scroll_reg;
    logic       full_reg;

    logic [6:0]        ccol_reg [CURSOR_STACK_DEPTH];
    logic [4:0]        crow_reg [CURSOR_STACK_DEPTH];
    logic [CCNT_W-1:0] ccnt_reg;
    logic [7:0]        astk_reg [ATTRIB_STACK_DEPTH];
    logic [ACNT_W-1:0] acnt_reg;

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    logic [CIDX_W-1:0] ck;
    logic [AIDX_W-1:0] ak;
    logic [6:0]        cols_eff;
    logic [4:0]        rows_eff;
    logic [7:0]        top_attr;
    logic              out_free;
    logic              put_wrap;
    logic              c_full, a_full;

    eng_req_t  ereq;
    eng_stat_t estat;

    tws_cell_engine u_engine (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (ereq),
        .stat   (estat)
    );

    assign ck       = CIDX_W'(ccnt_reg - 1'b1);
    assign ak       = AIDX_W'(acnt_reg - 1'b1);
    assign cols_eff = (cols_reg == 7'd0) ? 7'd1 : cols_reg;
    assign rows_eff = (rows_reg == 5'd0) ? 5'd1 : rows_reg;
    assign top_attr = astk_reg[ak];
    assign out_free = !m_tvalid_reg || m_tready;
    assign put_wrap = (ccol_reg[ck] >= cols_eff);
    assign c_full   = ((kind_reg == K_PUSH_CCUR) || (kind_reg == K_PUSH_CUR)) &&
                      (ccnt_reg >= CCNT_W'(CURSOR_STACK_DEPTH));
    assign a_full   = ((kind_reg == K_PUSH_CATT) || (kind_reg == K_PUSH_ATT)) &&
                      (acnt_reg >= ACNT_W'(ATTRIB_STACK_DEPTH));

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        ereq      = '0;
        ereq.cols = {1'b0, cols_eff};
        ereq.rows = {1'b0, rows_eff};
        ereq.x    = signed'({3'b000, left_reg});
        ereq.y    = signed'({5'b00000, top_reg});
        ereq.data = {top_attr, 8'd0};
        if (state_reg == ST_EXEC) begin
            unique case (kind_reg)
                K_BORDER: begin
                    ereq.go   = 1'b1;
                    ereq.op   = OP_BORDER;
                    ereq.x    = signed'({3'b000, left_reg}) - 10'sd1;
                    ereq.y    = signed'({5'b00000, top_reg}) - 10'sd1;
                    ereq.data = {av_reg, 7'd0, thick_reg};
                end
                K_READ: begin
                    ereq.go = 1'b1;
                    ereq.op = OP_READ;
                    ereq.x  = signed'({3'b000, pc_reg});
                    ereq.y  = signed'({5'b00000, pr_reg});
                end
                K_RECOL: begin
                    ereq.go = 1'b1;
                    ereq.op = OP_RECOL;
                end
                default: ereq.go = 1'b0;
            endcase
        end else if (state_reg == ST_PUTCHK) begin
            ereq.go = 1'b1;
            if (wr_reg >= rows_eff) begin
                ereq.op = OP_SCROLL;
            end else begin
                ereq.op   = OP_WRITE;
                ereq.x    = signed'({3'b000, left_reg}) + signed'({3'b000, wc_reg});
                ereq.y    = signed'({5'b00000, top_reg}) + signed'({5'b00000, wr_reg});
                ereq.data = {top_attr, ch_reg};
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (estat.ready) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC: begin
                priority if (kind_reg == K_PUT && ch_reg != CH_NEWLINE) state_next = ST_PUTCHK;
                else if (kind_reg == K_BORDER || kind_reg == K_READ || kind_reg == K_RECOL)
                    state_next = ST_WAIT;
                else state_next = ST_OUT;
            end
            ST_PUTCHK: state_next = ST_WAIT;
            ST_WAIT: if (estat.done) state_next = after_scroll_reg ? ST_PUTCHK : ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            left_reg         <= 7'd0;
            top_reg          <= 5'd0;
            cols_reg         <= 7'd80;
            rows_reg         <= 5'd25;
            dattr_reg        <= 8'd7;
            ccnt_reg         <= CCNT_W'(1);
            acnt_reg         <= ACNT_W'(1);
            m_tvalid_reg     <= 1'b0;
            after_scroll_reg <= 1'b0;
            full_reg         <= 1'b0;
            for (int i = 0; i < CURSOR_STACK_DEPTH; i++) begin
                ccol_reg[i] <= 7'd0;
                crow_reg[i] <= 5'd0;
            end
            for (int i = 0; i < ATTRIB_STACK_DEPTH; i++) begin
                astk_reg[i] <= (i == 0) ? 8'd7 : 8'd0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                unique case (cfg_index)
                    R_LEFT:  left_reg  <= cfg_data[6:0];
                    R_TOP:   top_reg   <= cfg_data[4:0];
                    R_COLS:  cols_reg  <= cfg_data[6:0];
                    R_ROWS:  rows_reg  <= cfg_data[4:0];
                    R_DATTR: dattr_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (state_reg == ST_EXEC) begin
                full_reg <= c_full || a_full;
                // wrap target for a printable put
                wc_reg   <= put_wrap ? 7'd0 : ccol_reg[ck];
                wr_reg   <= (put_wrap && crow_reg[ck] < ROW_LIMIT) ? crow_reg[ck] + 5'd1
                                                                   : crow_reg[ck];
                unique case (kind_reg)
                    K_PUT: begin
                        if (ch_reg == CH_NEWLINE) begin
                            ccol_reg[ck] <= 7'd0;
                            if (crow_reg[ck] < ROW_LIMIT) crow_reg[ck] <= crow_reg[ck] + 5'd1;
                        end
                    end
                    K_MOVE: begin
                        ccol_reg[ck] <= pc_reg;
                        crow_reg[ck] <= pr_reg;
                    end
                    K_PUSH_CCUR, K_PUSH_CUR: begin
                        if (!c_full) begin
                            ccol_reg[CIDX_W'(ccnt_reg)] <=
                                (kind_reg == K_PUSH_CCUR) ? ccol_reg[ck] : pc_reg;
                            crow_reg[CIDX_W'(ccnt_reg)] <=
                                (kind_reg == K_PUSH_CCUR) ? crow_reg[ck] : pr_reg;
                            ccnt_reg <= ccnt_reg + 1'b1;
                        end
                    end
                    K_POP_CUR: begin
                        if (ccnt_reg > CCNT_W'(1)) begin
                            ccnt_reg <= ccnt_reg - 1'b1;
                        end else begin
                            ccol_reg[0] <= 7'd0;
                            crow_reg[0] <= 5'd0;
                        end
                    end
                    K_PUSH_CATT, K_PUSH_ATT: begin
                        if (!a_full) begin
                            astk_reg[AIDX_W'(acnt_reg)] <=
                                (kind_reg == K_PUSH_CATT) ? top_attr : av_reg;
                            acnt_reg <= acnt_reg + 1'b1;
                        end
                    end
                    K_POP_ATT: begin
                        if (acnt_reg > ACNT_W'(1)) acnt_reg <= acnt_reg - 1'b1;
                        else astk_reg[0] <= dattr_reg;
                    end
                    default: ;
                endcase
            end

            if (state_reg == ST_PUTCHK) begin
                if (wr_reg >= rows_eff) begin
                    after_scroll_reg <= 1'b1;
                    wr_reg           <= wr_reg - 5'd1;
                end else begin
                    after_scroll_reg <= 1'b0;
                    ccol_reg[ck]     <= wc_reg + 7'd1;
                    crow_reg[ck]     <= wr_reg;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg  <= s_tuser;
            ch_reg    <= s_tdata[7:0];
            pc_reg    <= s_tdata[14:8];
            pr_reg    <= s_tdata[19:15];
            av_reg    <= s_tdata[27:20];
            thick_reg <= s_tdata[28];
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {3'd0, full_reg, top_attr, crow_reg[ck], ccol_reg[ck],
                            (kind_reg == K_READ) ? estat.rdata : 16'd0};
        end
    end

    a_ccnt: assert property (@(posedge aclk) disable iff (!aresetn)
        ccnt_reg >= CCNT_W'(1) && ccnt_reg <= CCNT_W'(CURSOR_STACK_DEPTH))
        else $error("cursor stack count out of range");
    a_acnt: assert property (@(posedge aclk) disable iff (!aresetn)
        acnt_reg >= ACNT_W'(1) && acnt_reg <= ACNT_W'(ATTRIB_STACK_DEPTH))
        else $error("attribute stack count out of range");
    a_wait_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUTCHK) |=> !estat.ready)
        else $error("engine ignored put request");
endmodule
